### src/mstt_pkg.sv
// package for the multi-slot periodic timer table
// holds field widths, function and kind codes and the slot store word layout
// no dependencies

package mstt_pkg;

    localparam int NOW_W  = 64;
    localparam int IVAL_W = 32;
    localparam int CNT_W  = 32;

    // input function code
    typedef enum logic {
        FUNC_INSTALL = 1'b0,
        FUNC_TICK    = 1'b1
    } t_func;

    // result kind code
    typedef enum logic {
        KIND_ACK  = 1'b0,
        KIND_FIRE = 1'b1
    } t_kind;

    // one entry of the slot store
    typedef struct packed {
        logic [NOW_W-1:0]  deadline;
        logic [CNT_W-1:0]  remaining;
        logic [IVAL_W-1:0] interval;
    } t_slot_word;

endpackage

### src/mstt_if.sv
// valid/ready channel interfaces of the timer table
// depends on mstt_pkg for field widths

interface mstt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [mstt_pkg::NOW_W-1:0]    now;
    logic [mstt_pkg::IVAL_W-1:0]   interval;
    logic [mstt_pkg::CNT_W-1:0]    repeat_count;

    modport source (output valid, func, now, interval, repeat_count, input ready);
    modport sink   (input valid, func, now, interval, repeat_count, output ready);
endinterface

interface mstt_out_if #(
    parameter int SLOT_W = 6
);
    logic              valid;
    logic              ready;
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic              table_full;
    logic              removed;
    logic              last;

    modport source (output valid, kind, slot, table_full, removed, last, input ready);
    modport sink   (input valid, kind, slot, table_full, removed, last, output ready);
endinterface

### src/multi_slot_periodic_timer_table.sv
// Install: one free-slot probe per cycle from slot 0, taking the lowest free slot;
//   a full table answers without probing.
// Tick: one slot per cycle through the slot store read port, except while a firing
//   waits on a stalled result side; one shared 64-bit adder and one comparator.
// One item at a time; the input is ready again once the last result, if any, is registered.
// Reset clears the active bits and count; the slot store has no clearing pass.
// depends on mstt_pkg, mstt_if and mstt_ram

module multi_slot_periodic_timer_table #(
    parameter int SLOTS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mstt_in_if.sink    i_in,
    mstt_out_if.source o_out
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int WW = $bits(mstt_pkg::t_slot_word);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INST,
        S_TICK
    } t_state;

    t_state r_state, n_state;

    // latched input item
    logic                        r_func,  n_func;
    logic [mstt_pkg::NOW_W-1:0]  r_now,   n_now;
    logic [mstt_pkg::IVAL_W-1:0] r_ival,  n_ival;
    logic [mstt_pkg::CNT_W-1:0]  r_cnt,   n_cnt;

    // slot bookkeeping
    logic [SLOTS-1:0] r_active, n_active;
    logic [CW-1:0]    r_total,  n_total;

    // scan pipeline
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic          r_ev_vld, n_ev_vld;
    logic [IW-1:0] r_ev_idx, n_ev_idx;

    // held firing result, sent once the next one or the scan end is known
    logic          r_pend,     n_pend;
    logic [IW-1:0] r_pend_slot, n_pend_slot;
    logic          r_pend_rem, n_pend_rem;

    // output register
    logic          r_out_valid, n_out_valid;
    logic          r_out_kind,  n_out_kind;
    logic [CW-1:0] r_out_slot,  n_out_slot;
    logic          r_out_full,  n_out_full;
    logic          r_out_rem,   n_out_rem;
    logic          r_out_last,  n_out_last;

    // slot store port
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    mstt_pkg::t_slot_word ram_wdata;
    logic                 ram_re;
    mstt_pkg::t_slot_word ram_rdata;

    // shared arithmetic
    logic [mstt_pkg::IVAL_W-1:0] add_op;
    logic [mstt_pkg::NOW_W-1:0]  sum;
    logic                        due;
    logic                        out_free;
    logic                        stall;
    logic [mstt_pkg::CNT_W-1:0]  rem_dec;
    logic                        freed;

    mstt_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    // one adder shared by install and tick; the comparator serves the tick scan
    assign add_op  = (r_state == S_INST) ? r_ival : ram_rdata.interval;
    assign sum     = r_now + {{(mstt_pkg::NOW_W - mstt_pkg::IVAL_W){1'b0}}, add_op};
    assign due     = r_ev_vld && r_active[r_ev_idx] && (ram_rdata.deadline < r_now);
    assign rem_dec = (ram_rdata.remaining != '0) ? ram_rdata.remaining - 1'b1
                                                 : ram_rdata.remaining;
    assign freed   = (ram_rdata.remaining == {{(mstt_pkg::CNT_W-1){1'b0}}, 1'b1});

    assign out_free = !r_out_valid || o_out.ready;
    assign stall    = due && r_pend && !out_free;

    // handshake ports
    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out_kind;
    assign o_out.slot       = r_out_slot;
    assign o_out.table_full = r_out_full;
    assign o_out.removed    = r_out_rem;
    assign o_out.last       = r_out_last;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_now       = r_now;
        n_ival      = r_ival;
        n_cnt       = r_cnt;
        n_active    = r_active;
        n_total     = r_total;
        n_rd_idx    = r_rd_idx;
        n_ev_vld    = r_ev_vld;
        n_ev_idx    = r_ev_idx;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_pend_rem  = r_pend_rem;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_full  = r_out_full;
        n_out_rem   = r_out_rem;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_ev_idx;
        ram_wdata   = '{deadline: sum, remaining: rem_dec, interval: ram_rdata.interval};
        ram_re      = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func   = i_in.func;
                    n_now    = i_in.now;
                    n_ival   = i_in.interval;
                    n_cnt    = i_in.repeat_count;
                    n_rd_idx = '0;
                    n_ev_vld = 1'b0;
                    n_pend   = 1'b0;
                    n_state  = (i_in.func == mstt_pkg::FUNC_TICK) ? S_TICK : S_INST;
                end
            end

            S_INST: begin
                if (r_total == CW'(SLOTS)) begin
                    // table full: one acknowledge with the full flag
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = mstt_pkg::KIND_ACK;
                        n_out_slot  = CW'(SLOTS);
                        n_out_full  = 1'b1;
                        n_out_rem   = 1'b0;
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (!r_active[r_rd_idx[IW-1:0]]) begin
                    // lowest free slot found
                    if (out_free) begin
                        ram_we      = 1'b1;
                        ram_waddr   = r_rd_idx[IW-1:0];
                        ram_wdata   = '{deadline: sum, remaining: r_cnt, interval: r_ival};
                        n_active[r_rd_idx[IW-1:0]] = 1'b1;
                        n_total     = r_total + 1'b1;
                        n_out_valid = 1'b1;
                        n_out_kind  = mstt_pkg::KIND_ACK;
                        n_out_slot  = r_rd_idx;
                        n_out_full  = 1'b0;
                        n_out_rem   = 1'b0;
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end

            S_TICK: begin
                if (!stall) begin
                    // evaluate the slot whose entry the last issued read returned
                    if (due) begin
                        ram_we = 1'b1;
                        if (freed) begin
                            n_active[r_ev_idx] = 1'b0;
                            n_total = r_total - 1'b1;
                        end
                        if (r_pend) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = mstt_pkg::KIND_FIRE;
                            n_out_slot  = CW'(r_pend_slot);
                            n_out_full  = 1'b0;
                            n_out_rem   = r_pend_rem;
                            n_out_last  = 1'b0;
                        end
                        n_pend      = 1'b1;
                        n_pend_slot = r_ev_idx;
                        n_pend_rem  = freed;
                    end
                    // issue the next read
                    if (r_rd_idx != CW'(SLOTS)) begin
                        ram_re   = 1'b1;
                        n_ev_vld = 1'b1;
                        n_ev_idx = r_rd_idx[IW-1:0];
                        n_rd_idx = r_rd_idx + 1'b1;
                    end else begin
                        n_ev_vld = 1'b0;
                    end
                end
                // scan done: flush the held result as the last one
                if (!r_ev_vld && r_rd_idx == CW'(SLOTS)) begin
                    if (!r_pend) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = mstt_pkg::KIND_FIRE;
                        n_out_slot  = CW'(r_pend_slot);
                        n_out_full  = 1'b0;
                        n_out_rem   = r_pend_rem;
                        n_out_last  = 1'b1;
                        n_pend      = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_total     <= '0;
            r_ev_vld    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_idx    <= '0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_total     <= n_total;
            r_ev_vld    <= n_ev_vld;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_rd_idx    <= n_rd_idx;
        end
        r_func      <= n_func;
        r_now       <= n_now;
        r_ival      <= n_ival;
        r_cnt       <= n_cnt;
        r_ev_idx    <= n_ev_idx;
        r_pend_slot <= n_pend_slot;
        r_pend_rem  <= n_pend_rem;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_full  <= n_out_full;
        r_out_rem   <= n_out_rem;
        r_out_last  <= n_out_last;
    end

    // active count tracks the active bits
    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == CW'($countones(r_active)))
        else $error("active count does not match active bits");

    // a held firing exists only during a tick scan
    a_pend_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend || r_ev_vld) |-> (r_state == S_TICK))
        else $error("scan state outside tick");

    // full flag only on an install acknowledge with slot equal to the slot count
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_full) |->
            (r_out_kind == mstt_pkg::KIND_ACK && !r_out_rem && r_out_slot == CW'(SLOTS)))
        else $error("bad full result");

    // a freed slot is inactive right after its firing
    a_freed_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && due && !stall && freed) |=> !r_active[$past(r_ev_idx)])
        else $error("freed slot still active");

endmodule

### src/mstt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module mstt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read, read data holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
